@@ design/cesd_pkg.sv @@
package cesd_pkg;

  // One source character of the capability text.
  typedef struct packed {
    logic [7:0] in_char;
  } item_t;

  // One decoded result beat.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic [1:0] error_code;
    logic       field_end;
    logic       comma_missing;
  } result_t;

  typedef enum logic [1:0] {
    ERR_NONE      = 2'd0,
    ERR_NO_EQUALS = 2'd1,
    ERR_BAD_CARET = 2'd2,
    ERR_TOO_LONG  = 2'd3
  } err_e;

  typedef enum logic [2:0] {
    MODE_EQ    = 3'd0,
    MODE_BODY  = 3'd1,
    MODE_CARET = 3'd2,
    MODE_BSL   = 3'd3,
    MODE_SKIP  = 3'd4,
    MODE_SKESC = 3'd5
  } mode_e;

  // Decision for one character: next parser mode, count update, result.
  typedef struct packed {
    mode_e   mode_nxt;
    logic    cnt_clr;
    logic    cnt_inc;
    logic    has_result;
    result_t res;
  } step_t;

endpackage

@@ design/cesd_stream_if.sv @@
interface cesd_stream_if #(
  parameter type T = logic [7:0]
) ();

  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);

endinterface

@@ design/capability_string_escape_decoder.sv @@
// Channel   Modport  Payload                                          Beat taken when
// --------  -------  -----------------------------------------------  -----------------
// in_i      sink     in_char                                          valid && ready
// out_o     source   out_byte, byte_valid, error_code, field_end,     valid && ready
//                    comma_missing
//
// One character is taken every cycle when the result side keeps up. A taken character
// sits in the input register while it is decoded against the parser mode and byte
// count, and its result (if any) is written into the output register once the result
// slot is free or is being emptied.
// Reset clears both valid flags, sets the parser to expect '=' and zeroes the count.
// A stalled output only blocks the input when the input register also holds a beat.
module capability_string_escape_decoder #(
  parameter int MAX_LEN = 255
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  cesd_stream_if.sink          in_i,
  cesd_stream_if.source        out_o
);

  import cesd_pkg::*;

  localparam int CntW = $clog2(MAX_LEN + 1);

  // Input stage: one character waiting for the decoder.
  logic       in_valid_q;
  logic [7:0] in_char_q;

  // Parser state carried from character to character.
  mode_e           mode_q, mode_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  // Result stage.
  logic    out_valid_q;
  result_t out_data_q;

  logic  proc;
  logic  at_limit;
  step_t step;

  // The held character is decoded as soon as the result slot is free or is
  // being emptied in this cycle. Characters that give no result still advance.
  assign proc     = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !in_valid_q || proc;

  assign at_limit = (cnt_q >= CntW'(MAX_LEN));

  cesd_decode u_decode (
    .mode_i     (mode_q),
    .at_limit_i (at_limit),
    .char_i     (in_char_q),
    .step_o     (step)
  );

  always_comb begin
    mode_d = mode_q;
    cnt_d  = cnt_q;
    if (proc) begin
      mode_d = step.mode_nxt;
      if (step.cnt_clr) begin
        cnt_d = '0;
      end else if (step.cnt_inc) begin
        cnt_d = cnt_q + CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      mode_q      <= MODE_EQ;
      cnt_q       <= '0;
    end else begin
      mode_q <= mode_d;
      cnt_q  <= cnt_d;
      if (in_i.ready) begin
        in_valid_q <= in_i.valid;
      end
      if (proc) begin
        out_valid_q <= step.has_result;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_char_q <= in_i.data.in_char;
    end
    if (proc && step.has_result) begin
      out_data_q <= step.res;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(MAX_LEN))
    else $error("byte count passed the length limit");

  a_byte_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_data_q.byte_valid |->
      (out_data_q.error_code == ERR_NONE) && !out_data_q.field_end)
    else $error("decoded byte shares a beat with an error or field end");

  a_cmiss_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_data_q.comma_missing |-> out_data_q.field_end)
    else $error("missing comma flagged without a field end");

  a_end_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc && step.res.field_end |=> (mode_q == MODE_EQ) && (cnt_q == '0))
    else $error("parser did not restart after a field end");

  a_result_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc && step.has_result |=> out_valid_q)
    else $error("decoded result lost on its way to the output register");
`endif

endmodule

@@ design/cesd_decode.sv @@
module cesd_decode (
  input  cesd_pkg::mode_e mode_i,
  input  logic            at_limit_i,
  input  logic [7:0]      char_i,
  output cesd_pkg::step_t step_o
);

  import cesd_pkg::*;

  localparam logic [7:0] ChNul   = 8'h00;
  localparam logic [7:0] ChEq    = 8'h3D;
  localparam logic [7:0] ChComma = 8'h2C;
  localparam logic [7:0] ChCaret = 8'h5E;
  localparam logic [7:0] ChBsl   = 8'h5C;
  localparam logic [7:0] ChSpace = 8'h20;

  function automatic logic [7:0] escape_map(input logic [7:0] c);
    logic [7:0] b;
    case (c)
      8'h45, 8'h65: b = 8'h1B;  // E, e
      8'h6E, 8'h6C: b = 8'h0A;  // n, l
      8'h72:        b = 8'h0D;  // r
      8'h74:        b = 8'h09;  // t
      8'h62:        b = 8'h08;  // b
      8'h66:        b = 8'h0C;  // f
      8'h73:        b = 8'h20;  // s
      8'h30:        b = 8'h40;  // 0
      default:      b = c;
    endcase
    return b;
  endfunction

  logic       is_blank;
  logic       caret_ok;
  logic       do_emit;
  logic       do_skip;
  logic [7:0] emit_byte;
  step_t      s;

  assign is_blank = (char_i == ChSpace) || ((char_i >= 8'h09) && (char_i <= 8'h0D));
  assign caret_ok = (char_i[7:5] == 3'b010);

  always_comb begin
    s           = '0;
    s.mode_nxt  = mode_i;
    do_emit     = 1'b0;
    do_skip     = 1'b0;
    emit_byte   = char_i;

    unique case (mode_i)
      MODE_EQ: begin
        if (char_i == ChEq) begin
          s.mode_nxt = MODE_BODY;
          s.cnt_clr  = 1'b1;
        end else begin
          s.res.error_code = ERR_NO_EQUALS;
          do_skip          = 1'b1;
        end
      end
      MODE_BODY: begin
        if (char_i == ChNul || char_i == ChComma) begin
          s.res.field_end     = 1'b1;
          s.res.comma_missing = (char_i == ChNul);
          s.mode_nxt          = MODE_EQ;
          s.cnt_clr           = 1'b1;
        end else if (char_i == ChCaret) begin
          s.mode_nxt = MODE_CARET;
        end else if (char_i == ChBsl) begin
          s.mode_nxt = MODE_BSL;
        end else if (!is_blank) begin
          do_emit = 1'b1;
        end
      end
      MODE_CARET: begin
        if (caret_ok) begin
          do_emit   = 1'b1;
          emit_byte = {3'b000, char_i[4:0]};
        end else begin
          s.res.error_code = ERR_BAD_CARET;
          do_skip          = 1'b1;
        end
      end
      MODE_BSL: begin
        if (char_i == ChNul) begin
          s.res.field_end     = 1'b1;
          s.res.comma_missing = 1'b1;
          s.mode_nxt          = MODE_EQ;
          s.cnt_clr           = 1'b1;
        end else begin
          do_emit   = 1'b1;
          emit_byte = escape_map(char_i);
        end
      end
      MODE_SKESC: begin
        if (char_i == ChNul) begin
          s.res.field_end     = 1'b1;
          s.res.comma_missing = 1'b1;
          s.mode_nxt          = MODE_EQ;
          s.cnt_clr           = 1'b1;
        end else begin
          s.mode_nxt = MODE_SKIP;
        end
      end
      default: begin
        do_skip = 1'b1;
      end
    endcase

    // Skipping starts with the current character still unconsumed.
    if (do_skip) begin
      if (char_i == ChNul || char_i == ChComma) begin
        s.res.field_end     = 1'b1;
        s.res.comma_missing = (char_i == ChNul);
        s.mode_nxt          = MODE_EQ;
        s.cnt_clr           = 1'b1;
      end else if (char_i == ChBsl) begin
        s.mode_nxt = MODE_SKESC;
      end else begin
        s.mode_nxt = MODE_SKIP;
      end
    end

    if (do_emit) begin
      if (at_limit_i) begin
        s.res.error_code = ERR_TOO_LONG;
        s.mode_nxt       = MODE_SKIP;
      end else begin
        s.res.out_byte   = emit_byte;
        s.res.byte_valid = 1'b1;
        s.cnt_inc        = 1'b1;
        s.mode_nxt       = MODE_BODY;
      end
    end

    s.has_result = s.res.byte_valid || (s.res.error_code != ERR_NONE) || s.res.field_end;
  end

  assign step_o = s;

endmodule
